// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted max-priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue depth, one cell per entry
  localparam int CAPACITY = 16;
  // Entry and priority width
  localparam int DATA_W   = 32;
  // Fill count width, holds 0 .. CAPACITY
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes
  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Holds a single entry; on insert it keeps its
// entry, takes the new value or takes its left neighbor's entry; on remove it
// takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk_i,
  input  spq_pkg::cell_cmd_t               cmd_i,
  input  logic                             occupied_i,
  input  logic                             ins_left_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_left_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_right_i,
  output logic                             ins_o,
  output logic signed [spq_pkg::DATA_W-1:0] value_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] value_d;

  // Insert point: empty slot, or stored entry strictly below the new value
  assign ins_o = !occupied_i || (value_q < cmd_i.value);

  // Shift right on insert, shift left on remove
  always_comb begin
    value_d = value_q;
    if (cmd_i.enq && ins_o) begin
      value_d = ins_left_i ? value_left_i : cmd_i.value;
    end else if (cmd_i.deq) begin
      value_d = value_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- rtl/core/sorted_max_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_unit
// Bounded max-priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the input word is taken.
// Throughput: one word per cycle while the result side is not stalled; the
//   whole cell row compares and shifts together. A stalled result
//   word holds the input until the result is taken.
// Reset: clears the fill count and the output valid; entries are not cleared.
module sorted_max_priority_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [spq_pkg::DATA_W-1:0] removed_value_o,
  output logic [spq_pkg::CNT_W-1:0]         occupancy_o
);
  import spq_pkg::*;

  logic                     in_accept;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  cell_cmd_t                cmd;
  logic [CAPACITY-1:0]      occupied;
  logic [CAPACITY-1:0]      ins;
  logic [CAPACITY-1:0]      ins_left;
  logic signed [DATA_W-1:0] cell_val   [CAPACITY];
  logic signed [DATA_W-1:0] left_val   [CAPACITY];
  logic signed [DATA_W-1:0] right_val  [CAPACITY];
  logic                     out_valid_q;
  status_e                  status_q;
  status_e                  status_d;
  logic signed [DATA_W-1:0] removed_q;
  logic signed [DATA_W-1:0] removed_d;

  // Handshake: take a word unless a result is waiting and stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Command to the cell row
  always_comb begin
    cmd.enq   = in_accept && (op_e'(op_i) == OP_ENQ) && !full;
    cmd.deq   = in_accept && (op_e'(op_i) == OP_DEQ) && !empty;
    cmd.value = value_i;
  end

  // Cell row with neighbor links
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occupied[g] = (CNT_W'(g) < count_q);

    if (g == 0) begin : g_first
      assign ins_left[g] = 1'b0;
      assign left_val[g] = value_i;
    end else begin : g_mid
      assign ins_left[g] = ins[g-1];
      assign left_val[g] = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val[g] = cell_val[g];
    end else begin : g_inner
      assign right_val[g] = cell_val[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied[g]),
      .ins_left_i   (ins_left[g]),
      .value_left_i (left_val[g]),
      .value_right_i(right_val[g]),
      .ins_o        (ins[g]),
      .value_o      (cell_val[g])
    );
  end

  // Fill count and result word
  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    removed_d = '0;
    if (op_e'(op_i) == OP_ENQ) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        count_d   = count_q - CNT_W'(1);
        removed_d = cell_val[0];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q <= count_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      occupancy_o <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;

  // Fill count stays within the row
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A successful insert grows the queue by one
  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the queue");

  // Every taken word yields a result word
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted word gave no result");

  // Occupied cells stay in descending order
  for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_order_chk
    a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
      occupied[k+1] |-> cell_val[k] >= cell_val[k+1])
      else $error("cell row out of order");
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_max_priority_queue_unit. A queue of words is
// driven in random bursts while the result side stalls on its own pattern.
// A local sorted-list model predicts every result word, and each result is
// checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import spq_pkg::*;

  // One input word and one predicted result word
  typedef struct {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } queue_cmd_t;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W-1:0]         occ;
  } queue_result_t;

  // DUT ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     op_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] removed_value_o;
  logic [CNT_W-1:0]         occupancy_o;

  // Stimulus and expectations
  queue_cmd_t    cmd_backlog[$];
  queue_result_t expected_results[$];

  // Local copy of the sorted queue contents
  logic signed [DATA_W-1:0] sorted_copy [CAPACITY];
  int                       sorted_fill = 0;

  // Handshake bookkeeping between the sampling and driving edges
  bit word_taken = 1'b0;
  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_left = 0;

  // Run statistics
  int errors       = 0;
  int n_results    = 0;
  int n_removed    = 0;
  int n_underflow  = 0;
  int n_overflow   = 0;
  int n_full_seen  = 0;

  sorted_max_priority_queue_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .occupancy_o     (occupancy_o)
  );

  // Clock, 2 ns period
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Sorted insert / front removal on the local copy
  task automatic predict_queue_op(input queue_cmd_t cmd, output queue_result_t res);
    int pos;
    res.status  = ST_OK;
    res.removed = '0;
    if (cmd.op == OP_ENQ) begin
      if (sorted_fill >= CAPACITY) begin
        res.status = ST_OVERFLOW;
      end else begin
        // first slot holding a strictly smaller value; equal values stay ahead
        pos = sorted_fill;
        for (int i = sorted_fill - 1; i >= 0; i--)
          if (sorted_copy[i] < cmd.value) pos = i;
        for (int i = sorted_fill; i > pos; i--)
          sorted_copy[i] = sorted_copy[i-1];
        sorted_copy[pos] = cmd.value;
        sorted_fill++;
      end
    end else begin
      if (sorted_fill == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.removed = sorted_copy[0];
        for (int i = 1; i < sorted_fill; i++)
          sorted_copy[i-1] = sorted_copy[i];
        sorted_fill--;
      end
    end
    res.occ = CNT_W'(sorted_fill);
  endtask

  task automatic push_cmd(input op_e op, input logic signed [DATA_W-1:0] value);
    queue_cmd_t c;
    c.op    = op;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  // Monitor: check result words, then predict for the accepted input word
  always @(posedge clk_i) begin
    queue_cmd_t    cmd;
    queue_result_t res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word status %0d removed %0d occupancy %0d",
                   $time, status_o, removed_value_o, occupancy_o);
          errors++;
        end else begin
          res = expected_results.pop_front();
          n_results++;
          if (status_o !== res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, res.status, status_o);
            errors++;
          end
          if (removed_value_o !== res.removed) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, res.removed, removed_value_o);
            errors++;
          end
          if (occupancy_o !== res.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, res.occ, occupancy_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        cmd.op    = op_e'(op_i);
        cmd.value = value_i;
        predict_queue_op(cmd, res);
        expected_results.push_back(res);
        word_taken = 1'b1;
        case (res.status)
          ST_UNDERFLOW: n_underflow++;
          ST_OVERFLOW:  n_overflow++;
          default: if (cmd.op == OP_DEQ) n_removed++;
        endcase
        if (sorted_fill == CAPACITY) n_full_seen++;
      end
    end
  end

  // Driver: bursts of words separated by random gaps
  always @(negedge clk_i) begin
    queue_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // stalled, hold the word
    end else begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= c.op;
        value_i    <= c.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: free runs, random chatter and solid stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0:       stall_left = $urandom_range(1, 40);
        1:       stall_left = $urandom_range(1, 30);
        default: stall_left = $urandom_range(1, 12);
      endcase
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= 1'b1;
    endcase
  end

  // Stimulus and end of run
  initial begin
    int enq_pct;
    int vmode;
    int seg_len;
    int total;
    logic signed [DATA_W-1:0] v;

    // Directed: underflow, extremes, ties at front and rear, full and overflow
    push_cmd(OP_DEQ, 32'sh1234_5678);
    push_cmd(OP_ENQ, 32'sh7FFF_FFFF);
    push_cmd(OP_ENQ, 32'sh8000_0000);
    push_cmd(OP_ENQ, 32'sh8000_0000);
    push_cmd(OP_ENQ, 32'sh0000_0000);
    push_cmd(OP_ENQ, -32'sd1);
    push_cmd(OP_ENQ, 32'sh7FFF_FFFF);
    for (int i = 0; i < 10; i++) push_cmd(OP_ENQ, $urandom);
    push_cmd(OP_ENQ, 32'sh7FFF_FFFF);
    push_cmd(OP_DEQ, 32'shFFFF_FFFF);
    push_cmd(OP_ENQ, 32'sh8000_0000);
    push_cmd(OP_DEQ, 32'sh0000_0000);

    // Random segments, each with its own enqueue bias and value style
    total = 0;
    while (total < 1330) begin
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0:       enq_pct = 15;
        1:       enq_pct = 50;
        2:       enq_pct = 85;
        default: enq_pct = 60;
      endcase
      vmode = $urandom_range(0, 3);
      for (int i = 0; i < seg_len; i++) begin
        case (vmode)
          1: v = $signed($urandom_range(0, 8)) - 4;   // many ties
          2: begin
            case ($urandom_range(0, 5))
              0:       v = 32'sh7FFF_FFFF;
              1:       v = 32'sh8000_0000;
              2:       v = 32'sh7FFF_FFFE;
              3:       v = 32'sh8000_0001;
              4:       v = -32'sd1;
              default: v = '0;
            endcase
          end
          default: v = $urandom;
        endcase
        if ($urandom_range(1, 100) <= enq_pct) push_cmd(OP_ENQ, v);
        else push_cmd(OP_DEQ, $urandom);
      end
      total += seg_len;
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_backlog.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (5) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_results.size());
      errors++;
    end

    $display("Checked %0d result words: %0d removals, %0d underflows, %0d overflows,",
             n_results, n_removed, n_underflow, n_overflow);
    $display("queue was full after %0d words, %0d mismatches", n_full_seen, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("%0t: timeout", $time);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
